// ----- hdl/chtab_pkg.sv -----
// shared types, codes and constants of the chained hash table
package chtab_pkg;

  localparam int KEY_W   = 31;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 7;
  localparam int DEPTH_W = 6;

  localparam int DEF_BUCKETS   = 16;
  localparam int DEF_POOL_SIZE = 64;

  // remainder unit takes this many key bits per cycle
  localparam int MOD_DIGIT_W = 4;
  localparam int MOD_STEPS   = (KEY_W + MOD_DIGIT_W - 1) / MOD_DIGIT_W;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [KEY_W-1:0] key;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [CNT_W-1:0]   element_count;
    logic [DEPTH_W-1:0] chain_depth;
  } result_t;

  typedef struct packed {
    logic alloc;
    logic give_back;
  } pool_cmd_t;

  // index width for a store of n entries, at least one bit
  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ----- hdl/chained_hash_table_unit.sv -----
// hash table with separate chaining over a fixed node pool
//
// usage: present a request on req and raise start while busy is low; the
// request is taken at that clock edge and busy rises the next cycle. each
// request gives exactly one result on result, marked by done for a single
// cycle; the receiver cannot stall, it must take the result in that cycle.
// busy falls in the same cycle that done is high, so the next request can
// be taken right then.
// operation: the bucket index comes from a remainder unit that takes four
// key bits per cycle. insert then needs one head read and one write.
// search and delete walk the chain through the node memory, a read and
// then a compare per node. delete on an empty table and the unused opcode
// end right after the head lookup.
// reset: rst (synchronous) clears control state, then a clearing pass
// writes the null code to every bucket head, one per cycle, with busy high.
// node memories are not cleared: only linked nodes are read.
module chained_hash_table_unit #(
  parameter int BUCKETS   = chtab_pkg::DEF_BUCKETS,
  parameter int POOL_SIZE = chtab_pkg::DEF_POOL_SIZE
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  chtab_pkg::request_t req,
  output logic                done,
  output chtab_pkg::result_t  result
);
  import chtab_pkg::*;

  localparam int BW = idx_w(BUCKETS);
  localparam int IW = idx_w(POOL_SIZE);
  localparam int NW = $clog2(POOL_SIZE + 1);
  localparam logic [NW-1:0] NULL_CODE = NW'(POOL_SIZE);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_HASH, S_HEAD, S_FETCH, S_CHECK, S_CMP, S_INS
  } state_t;

  state_t           state;
  logic [BW-1:0]    clr_idx;
  logic [OP_W-1:0]  op;
  logic [KEY_W-1:0] key;
  logic [BW-1:0]    bkt;
  logic [NW-1:0]    cur;
  logic [NW-1:0]    prev;
  logic [NW-1:0]    depth;
  logic [NW-1:0]    entry_count;
  logic [NW-1:0]    cnt_inc;
  logic [NW-1:0]    cnt_dec;

  logic             mod_go;
  logic             mod_done;
  logic [BW-1:0]    mod_bkt;

  pool_cmd_t        pool_cmd;
  logic [IW-1:0]    pool_idx;
  logic             pool_empty;

  logic [NW-1:0]    bucket_head [BUCKETS];
  logic [NW-1:0]    head_q;
  logic             head_we;
  logic [BW-1:0]    head_waddr;
  logic [NW-1:0]    head_wdata;

  logic [KEY_W-1:0] node_key [POOL_SIZE];
  logic [NW-1:0]    node_next [POOL_SIZE];
  logic [KEY_W-1:0] key_q;
  logic [NW-1:0]    next_q;
  logic             node_we;
  logic             link_we;
  logic [IW-1:0]    node_waddr;
  logic [NW-1:0]    link_wdata;
  logic             hit;

  assign mod_go  = (state == S_IDLE) && start;
  assign busy    = (state != S_IDLE);
  assign cnt_inc = entry_count + NW'(1);
  assign cnt_dec = entry_count - NW'(1);
  assign hit     = (key_q == key);

  chtab_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk    (clk),
    .rst    (rst),
    .go     (mod_go),
    .key_in (req.key),
    .done   (mod_done),
    .bkt    (mod_bkt)
  );

  chtab_pool #(.POOL_SIZE(POOL_SIZE)) u_pool (
    .clk      (clk),
    .rst      (rst),
    .cmd      (pool_cmd),
    .give_idx (cur[IW-1:0]),
    .node_idx (pool_idx),
    .empty    (pool_empty)
  );

  // memory write controls
  always_comb begin
    head_we    = 1'b0;
    head_waddr = bkt;
    head_wdata = NULL_CODE;
    node_we    = 1'b0;
    link_we    = 1'b0;
    node_waddr = pool_idx;
    link_wdata = head_q;
    pool_cmd   = '0;
    unique case (state)
      S_CLR: begin
        head_we    = 1'b1;
        head_waddr = clr_idx;
      end
      S_CMP: begin
        if (hit && op == OP_DELETE) begin
          // unlink: predecessor or bucket head takes the successor
          if (prev == NULL_CODE) begin
            head_we    = 1'b1;
            head_wdata = next_q;
          end else begin
            link_we    = 1'b1;
            node_waddr = prev[IW-1:0];
            link_wdata = next_q;
          end
          pool_cmd.give_back = 1'b1;
        end
      end
      S_INS: begin
        if (!pool_empty) begin
          node_we        = 1'b1;
          head_we        = 1'b1;
          head_wdata     = NW'(pool_idx);
          pool_cmd.alloc = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      bucket_head[head_waddr] <= head_wdata;
    end
    head_q <= bucket_head[bkt];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_key[node_waddr] <= key;
    end
    if (node_we || link_we) begin
      node_next[node_waddr] <= link_wdata;
    end
    key_q  <= node_key[cur[IW-1:0]];
    next_q <= node_next[cur[IW-1:0]];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      clr_idx     <= '0;
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      unique case (state)
        S_CLR: begin
          done    <= 1'b0;
          clr_idx <= clr_idx + BW'(1);
          if (clr_idx == BW'(BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            op    <= req.opcode;
            key   <= req.key;
            state <= S_HASH;
          end
        end
        S_HASH: begin
          done <= 1'b0;
          if (mod_done) begin
            bkt   <= mod_bkt;
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          priority if (op == OP_INSERT) begin
            done  <= 1'b0;
            state <= S_INS;
          end else if (op == OP_SEARCH || (op == OP_DELETE && entry_count != '0)) begin
            done  <= 1'b0;
            state <= S_FETCH;
          end else begin
            done   <= 1'b1;
            result <= '{status: ST_MISS, element_count: CNT_W'(entry_count),
                        chain_depth: '0};
            state  <= S_IDLE;
          end
        end
        S_FETCH: begin
          done  <= 1'b0;
          cur   <= head_q;
          prev  <= NULL_CODE;
          depth <= '0;
          state <= S_CHECK;
        end
        S_CHECK: begin
          // walk guard: end of chain, bad link or pool-length walk
          if (cur >= NULL_CODE || depth == NULL_CODE) begin
            done   <= 1'b1;
            result <= '{status: ST_MISS, element_count: CNT_W'(entry_count),
                        chain_depth: '0};
            state  <= S_IDLE;
          end else begin
            done  <= 1'b0;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (hit) begin
            done  <= 1'b1;
            state <= S_IDLE;
            if (op == OP_DELETE) begin
              entry_count <= cnt_dec;
              result <= '{status: ST_OK, element_count: CNT_W'(cnt_dec),
                          chain_depth: DEPTH_W'(depth)};
            end else begin
              result <= '{status: ST_OK, element_count: CNT_W'(entry_count),
                          chain_depth: DEPTH_W'(depth)};
            end
          end else begin
            done  <= 1'b0;
            prev  <= cur;
            cur   <= next_q;
            depth <= depth + NW'(1);
            state <= S_CHECK;
          end
        end
        S_INS: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (pool_empty) begin
            result <= '{status: ST_FULL, element_count: CNT_W'(entry_count),
                        chain_depth: '0};
          end else begin
            entry_count <= cnt_inc;
            result <= '{status: ST_OK, element_count: CNT_W'(cnt_inc),
                        chain_depth: '0};
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken but busy did not rise");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= NULL_CODE)
    else $error("entry count exceeds pool size");

  a_pool_count: assert property (@(posedge clk) disable iff (rst)
    pool_empty == (entry_count == NULL_CODE))
    else $error("free pool and entry count disagree");
`endif

endmodule

// ----- hdl/chtab_mod.sv -----
// iterative key modulo bucket-count unit, MOD_DIGIT_W key bits per cycle
module chtab_mod #(
  parameter int BUCKETS = chtab_pkg::DEF_BUCKETS
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        go,
  input  logic [chtab_pkg::KEY_W-1:0]                 key_in,
  output logic                                        done,
  output logic [chtab_pkg::idx_w(BUCKETS)-1:0]        bkt
);
  import chtab_pkg::*;

  localparam int BW    = idx_w(BUCKETS);
  localparam int RW    = BW + 1;
  localparam int PAD_W = MOD_STEPS * MOD_DIGIT_W;
  localparam int CW    = idx_w(MOD_STEPS);
  localparam logic [RW-1:0] DIV = RW'(BUCKETS);

  logic          running;
  logic [CW-1:0] cnt;
  logic [PAD_W-1:0] sh;
  logic [BW-1:0] rem;
  logic [BW-1:0] rem_next;
  logic [RW-1:0] r;

  // r = (2r + bit) mod BUCKETS, one compare and subtract per bit
  always_comb begin
    r = RW'(rem);
    for (int i = 0; i < MOD_DIGIT_W; i++) begin
      r = {r[RW-2:0], sh[PAD_W-1-i]};
      if (r >= DIV) begin
        r = r - DIV;
      end
    end
    rem_next = r[BW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      if (go) begin
        sh      <= PAD_W'(key_in);
        rem     <= '0;
        cnt     <= '0;
        running <= 1'b1;
        done    <= 1'b0;
      end else if (running) begin
        sh  <= sh << MOD_DIGIT_W;
        rem <= rem_next;
        cnt <= cnt + CW'(1);
        if (cnt == CW'(MOD_STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign bkt = rem;

endmodule

// ----- hdl/chtab_pool.sv -----
// free node allocator: fresh-node counter plus a stack of recycled nodes
module chtab_pool #(
  parameter int POOL_SIZE = chtab_pkg::DEF_POOL_SIZE
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  chtab_pkg::pool_cmd_t                   cmd,
  input  logic [chtab_pkg::idx_w(POOL_SIZE)-1:0] give_idx,
  output logic [chtab_pkg::idx_w(POOL_SIZE)-1:0] node_idx,
  output logic                                   empty
);
  import chtab_pkg::*;

  localparam int IW = idx_w(POOL_SIZE);
  localparam int NW = $clog2(POOL_SIZE + 1);

  logic [NW-1:0] fresh;
  logic [NW-1:0] rcnt;
  logic [NW-1:0] rcnt_m1;
  logic [IW-1:0] stack [POOL_SIZE];
  logic [IW-1:0] stack_q;

  assign rcnt_m1  = rcnt - NW'(1);
  assign node_idx = (rcnt != '0) ? stack_q : fresh[IW-1:0];
  assign empty    = (rcnt == '0) && (fresh == NW'(POOL_SIZE));

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh <= '0;
      rcnt  <= '0;
    end else begin
      if (cmd.alloc) begin
        if (rcnt != '0) begin
          rcnt <= rcnt_m1;
        end else begin
          fresh <= fresh + NW'(1);
        end
      end else if (cmd.give_back) begin
        rcnt <= rcnt + NW'(1);
      end
    end
  end

  // top of stack is read every cycle into a register, so it settles in the cycle after a change
  always_ff @(posedge clk) begin
    if (cmd.give_back) begin
      stack[rcnt[IW-1:0]] <= give_idx;
    end
    stack_q <= stack[rcnt_m1[IW-1:0]];
  end

endmodule

// ----- tb/sv/chtab_checker.sv -----
`timescale 1ns / 100ps
// request/result checker with its own table model for the chained hash table
module chtab_checker #(
  parameter int BUCKETS   = chtab_pkg::DEF_BUCKETS,
  parameter int POOL_SIZE = chtab_pkg::DEF_POOL_SIZE
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  chtab_pkg::request_t req,
  input  logic                done,
  input  chtab_pkg::result_t  result,
  output int                  fail_count,
  output int                  outstanding
);
  import chtab_pkg::*;

  localparam int LINK_W = $clog2(POOL_SIZE + 1);
  // link value that marks the end of a chain
  localparam logic [LINK_W-1:0] NO_NODE = LINK_W'(POOL_SIZE);

  logic [LINK_W-1:0] chain_head  [BUCKETS];
  logic [KEY_W-1:0]  node_key_of [POOL_SIZE];
  logic [LINK_W-1:0] node_link   [POOL_SIZE];
  logic [LINK_W-1:0] free_nodes  [POOL_SIZE];
  logic [LINK_W-1:0] free_level;
  logic [CNT_W-1:0]  stored_count;
  result_t           expected_results [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic clear_table();
    for (int i = 0; i < BUCKETS; i++) chain_head[i] = NO_NODE;
    for (int i = 0; i < POOL_SIZE; i++) begin
      node_key_of[i] = '0;
      node_link[i]   = '0;
      free_nodes[i]  = LINK_W'(i);
    end
    free_level   = LINK_W'(POOL_SIZE);
    stored_count = '0;
  endtask

  // first node of bucket b that holds key, with its predecessor and position
  function automatic bit walk_chain(input logic [KEY_W-1:0] key, input int b,
                                    output int hit_node, output int prev_node,
                                    output int pos);
    int cur;
    cur       = chain_head[b];
    prev_node = POOL_SIZE;
    hit_node  = POOL_SIZE;
    pos       = 0;
    while (cur < POOL_SIZE && pos < POOL_SIZE) begin
      if (node_key_of[cur] == key) begin
        hit_node = cur;
        return 1'b1;
      end
      prev_node = cur;
      cur       = node_link[cur];
      pos++;
    end
    return 1'b0;
  endfunction

  function automatic result_t apply_table_request(input request_t r);
    result_t res;
    int      b;
    int      hit_node;
    int      prev_node;
    int      pos;
    int      slot;
    b               = r.key % BUCKETS;
    res.status      = ST_MISS;
    res.chain_depth = '0;
    case (r.opcode)
      OP_INSERT: begin
        if (free_level == 0) begin
          res.status = ST_FULL;
        end else begin
          free_level--;
          slot              = free_nodes[free_level];
          node_key_of[slot] = r.key;
          node_link[slot]   = chain_head[b];
          chain_head[b]     = LINK_W'(slot);
          stored_count++;
          res.status = ST_OK;
        end
      end
      OP_DELETE: begin
        if (stored_count != 0 && walk_chain(r.key, b, hit_node, prev_node, pos)) begin
          if (prev_node == POOL_SIZE) chain_head[b] = node_link[hit_node];
          else node_link[prev_node] = node_link[hit_node];
          free_nodes[free_level] = LINK_W'(hit_node);
          free_level++;
          stored_count--;
          res.status      = ST_OK;
          res.chain_depth = DEPTH_W'(pos);
        end
      end
      OP_SEARCH: begin
        if (walk_chain(r.key, b, hit_node, prev_node, pos)) begin
          res.status      = ST_OK;
          res.chain_depth = DEPTH_W'(pos);
        end
      end
      default: ;
    endcase
    res.element_count = stored_count;
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_table();
      expected_results.delete();
    end else begin
      // compare before queuing so a stray result never meets this edge's request
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result with no request waiting: status %0d count %0d depth %0d",
                 result.status, result.element_count, result.chain_depth);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            fail_count++;
          end
          if (result.element_count !== want.element_count) begin
            $error("element_count: expected %0d, got %0d",
                   want.element_count, result.element_count);
            fail_count++;
          end
          if (result.chain_depth !== want.chain_depth) begin
            $error("chain_depth: expected %0d, got %0d",
                   want.chain_depth, result.chain_depth);
            fail_count++;
          end
        end
      end
      if (start && !busy) expected_results.push_back(apply_table_request(req));
    end
    outstanding = expected_results.size();
  end

endmodule

// ----- tb/sv/tb_chained_hash_table_unit.sv -----
`timescale 1ns / 100ps
// top of the chained hash table testbench: clock, reset, request stimulus, verdict
module tb_chained_hash_table_unit;
  import chtab_pkg::*;

  localparam int CYCLE_LIMIT   = 1_200_000;
  localparam int SETTLE_CYCLES = 160;
  localparam int ITEM_TARGET   = 1820;
  localparam int QUIET_FROM    = ITEM_TARGET - 200;
  localparam int BUCKET_BITS   = $clog2(DEF_BUCKETS);

  localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX   = '1;

  logic     clk   = 1'b0;
  logic     rst   = 1'b1;
  logic     start = 1'b0;
  request_t req   = '0;
  logic     busy;
  logic     done;
  result_t  result;
  int       fail_count;
  int       outstanding;

  int cycle_count   = 0;
  int sent_total    = 0;
  int sent_by_op[4] = '{default: 0};
  int fills         = 0;
  int deep_fills    = 0;
  bit idle_on       = 1'b1;

  initial begin
    forever #2 clk = ~clk;
  end

  chained_hash_table_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
  );

  chtab_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .done        (done),
    .result      (result),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[chained_hash_table_unit] ERROR");
      $finish;
    end
  end

  // random upper bits over a chosen bucket
  function automatic logic [KEY_W-1:0] make_key(input logic [BUCKET_BITS-1:0] b);
    logic [31:0] r;
    r = $urandom;
    return {r[KEY_W-1:BUCKET_BITS], b};
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return KEY_MAX;
    return KEY_W'($urandom);
  endfunction

  // returns at the edge that took the request, or after an idle burst
  task automatic issue_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
    int gap;
    req   <= '{opcode: op, key: key};
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sent_total++;
    sent_by_op[op]++;
    if (idle_on && sent_total < QUIET_FROM && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      // half the bursts land after the block has gone idle
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk); while (busy);
      end
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every request has its result
  task automatic wait_drained();
    @(posedge clk);
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic mixed_episode();
    logic [KEY_W-1:0]       key_set [12];
    logic [BUCKET_BITS-1:0] bsel [3];
    logic [KEY_W-1:0]       k;
    int                     roll;
    foreach (bsel[i]) bsel[i] = BUCKET_BITS'($urandom);
    foreach (key_set[i]) key_set[i] = make_key(bsel[$urandom_range(0, 2)]);
    repeat (40) begin
      roll = $urandom_range(0, 99);
      k = ($urandom_range(0, 9) == 0) ? random_key() : key_set[$urandom_range(0, 11)];
      if (roll < 35) issue_request(OP_INSERT, k);
      else if (roll < 62) issue_request(OP_DELETE, k);
      else if (roll < 95) issue_request(OP_SEARCH, k);
      else issue_request(OP_UNUSED, k);
    end
  endtask

  // run the pool past full, then delete everything this episode put in
  task automatic fill_episode(input bit single_bucket);
    logic [KEY_W-1:0]       stored [$];
    logic [KEY_W-1:0]       k;
    logic [BUCKET_BITS-1:0] b;
    int                     pick;
    b = BUCKET_BITS'($urandom);
    fills++;
    if (single_bucket) deep_fills++;
    repeat (DEF_POOL_SIZE + $urandom_range(2, 6)) begin
      k = make_key(single_bucket ? b : BUCKET_BITS'($urandom));
      issue_request(OP_INSERT, k);
      stored.push_back(k);
      if ($urandom_range(0, 4) == 0)
        issue_request(OP_SEARCH, stored[$urandom_range(0, stored.size() - 1)]);
    end
    while (stored.size() > 0) begin
      pick = $urandom_range(0, stored.size() - 1);
      if ($urandom_range(0, 4) == 0) issue_request(OP_SEARCH, stored[pick]);
      issue_request(OP_DELETE, stored[pick]);
      stored.delete(pick);
      if ($urandom_range(0, 9) == 0) issue_request(OP_SEARCH, random_key());
    end
  endtask

  initial begin
    int roll;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty buckets must not match key 0
    issue_request(OP_SEARCH, '0);
    issue_request(OP_DELETE, '0);
    issue_request(OP_DELETE, KEY_MAX);
    issue_request(OP_INSERT, '0);
    issue_request(OP_SEARCH, '0);
    issue_request(OP_INSERT, KEY_MAX);
    issue_request(OP_SEARCH, KEY_MAX);
    issue_request(OP_INSERT, 31'd16);
    // duplicate key goes in front of the older copy
    issue_request(OP_INSERT, '0);
    issue_request(OP_SEARCH, 31'd16);
    issue_request(OP_SEARCH, '0);
    issue_request(OP_DELETE, '0);
    issue_request(OP_SEARCH, '0);
    issue_request(OP_DELETE, 31'd32);
    issue_request(OP_UNUSED, KEY_MAX);
    issue_request(OP_UNUSED, '0);
    issue_request(OP_DELETE, '0);
    issue_request(OP_DELETE, 31'd16);
    issue_request(OP_DELETE, KEY_MAX);
    issue_request(OP_SEARCH, KEY_MAX);
    wait_drained();

    while (sent_total < ITEM_TARGET) begin
      idle_on = ($urandom_range(0, 2) != 0);
      roll = $urandom_range(0, 99);
      if (roll < 6) fill_episode(1'b1);
      else if (roll < 16) fill_episode(1'b0);
      else mixed_episode();
      if (sent_total < QUIET_FROM && $urandom_range(0, 7) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d requests: %0d insert, %0d delete, %0d search, %0d unused opcode",
             sent_total, sent_by_op[OP_INSERT], sent_by_op[OP_DELETE],
             sent_by_op[OP_SEARCH], sent_by_op[OP_UNUSED]);
    $display("pool filled past full %0d times, %0d of them through one bucket chain",
             fills, deep_fills);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[chained_hash_table_unit] OK");
    end else begin
      $display("[chained_hash_table_unit] ERROR");
    end
    $finish;
  end

endmodule
